// ===== design/ptjs_pkg.sv =====
// Package for the priority tone job scheduler: widths, opcodes and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptjs_pkg;
	localparam int NUM_PRIORITIES_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int PRIO_W = 3;
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_SUBMIT = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP_ALL = 2'd2;
	localparam logic [OP_W-1:0] OP_TICK = 2'd3;
	localparam logic [63:0] FOREVER_END = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [PRIO_W-1:0] DEFAULT_PRIO_RESET = 3'd1;
endpackage
`default_nettype wire

// ===== design/ptjs_if.sv =====
// Valid/ready channel interfaces for the scheduler: request, result, config write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ptjs_req_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [2:0] job_priority;
	logic [15:0] wrap_count;
	logic [15:0] high_count;
	logic [31:0] duration_us;
	logic forever_req;
	modport source (output valid, opcode, job_priority, wrap_count, high_count,
		duration_us, forever_req, input ready);
	modport sink (input valid, opcode, job_priority, wrap_count, high_count,
		duration_us, forever_req, output ready);
endinterface

interface ptjs_rsp_if;
	logic valid;
	logic ready;
	logic accepted;
	logic active;
	logic [2:0] playing_priority;
	logic [15:0] pwm_wrap;
	logic [15:0] pwm_level;
	logic job_finished;
	logic [2:0] finished_priority;
	modport source (output valid, accepted, active, playing_priority, pwm_wrap,
		pwm_level, job_finished, finished_priority, input ready);
	modport sink (input valid, accepted, active, playing_priority, pwm_wrap,
		pwm_level, job_finished, finished_priority, output ready);
endinterface

interface ptjs_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/priority_tone_job_scheduler_core.sv =====
// Top level of the priority tone job scheduler: sequencer, queue memory, result register.
// Depends on ptjs_pkg and the channel interfaces in ptjs_if.sv.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time: the block takes a request, runs it through a small
// sequencer that touches the queue memory one entry per cycle (one read port,
// registered data), and presents one result. A plain request passes the idle
// state that takes it, a decode or tick state and the output register. A
// submit that goes to the back of a queue adds a read and a check of the
// queue front (ST_PUSH_RD, ST_PUSH_CHK), and both again when a full queue
// drops its stale front (at most one front is ever dropped). A search for
// the next job spends ST_PICK_RD on an empty queue, and ST_PICK_RD and
// ST_PICK_CHK on a queue whose front is read. The next request is taken
// once the result has left the output register. No clearing pass is needed
// after reset.
module priority_tone_job_scheduler_core
	import ptjs_pkg::*;
#(
	parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire clk,
	input wire arst_n,
	ptjs_req_if.sink req,
	ptjs_rsp_if.source rsp,
	ptjs_cfg_if.sink cfg
);
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MD = NUM_PRIORITIES * QUEUE_DEPTH;
	localparam int AW = (MD > 1) ? $clog2(MD) : 1;
	localparam int EW = 96;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DEC = 4'd1;
	localparam logic [3:0] ST_PUSH_RD = 4'd2;
	localparam logic [3:0] ST_PUSH_CHK = 4'd3;
	localparam logic [3:0] ST_PICK_RD = 4'd4;
	localparam logic [3:0] ST_PICK_CHK = 4'd5;
	localparam logic [3:0] ST_OUT = 4'd6;
	localparam logic [3:0] ST_TICK = 4'd7;

	logic [3:0] state_q;
	logic [PRIO_W-1:0] dflt_q;
	logic [63:0] time_q;
	logic [PRIO_W-1:0] level_q;
	logic [15:0] wwrap_q, whigh_q;
	logic [63:0] wend_q;
	logic [QW-1:0] head_q [NUM_PRIORITIES];
	logic [CW-1:0] count_q [NUM_PRIORITIES];

	// Latched request.
	logic [OP_W-1:0] op_q;
	logic [PRIO_W-1:0] prio_q;
	logic [15:0] nwrap_q, nhigh_q;
	logic [31:0] dur_q;
	logic fev_q;
	logic [63:0] nend_q;
	logic [63:0] now_q;
	logic [PW-1:0] qi_q;
	logic acc_q, fin_q;
	logic [PRIO_W-1:0] finp_q;

	// Queue memory: wrap, high and end time packed into one word.
	logic [EW-1:0] mem_q [MD];
	logic [EW-1:0] rd_q;
	logic mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [EW-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rd_q <= mem_q[mem_ra];
	end

	// The offset never exceeds the depth, so one compare and subtract wraps it.
	function automatic logic [AW-1:0] slot(input logic [PW-1:0] q, input logic [QW-1:0] h,
		input logic [CW-1:0] off);
		logic [QW+CW:0] s;
		s = {{(CW+1){1'b0}}, h} + {{(QW+1){1'b0}}, off};
		if (32'(s) >= QUEUE_DEPTH)
			s = s - (QW+CW+1)'(QUEUE_DEPTH);
		return AW'(32'(q) * QUEUE_DEPTH + 32'(s));
	endfunction

	function automatic logic [QW-1:0] inc_h(input logic [QW-1:0] h);
		return (32'(h) == QUEUE_DEPTH - 1) ? '0 : QW'(32'(h) + 1);
	endfunction

	// Effective priority and end time of the incoming request.
	logic [PRIO_W-1:0] eprio;
	logic [PRIO_W-1:0] praw;
	always_comb begin
		praw = (req.job_priority == '0) ? dflt_q : req.job_priority;
		eprio = (praw == '0 || 32'(praw) > NUM_PRIORITIES) ? '0 : praw;
	end
	logic [64:0] sum_end;
	assign sum_end = {1'b0, time_q} + {33'd0, req.duration_us};

	logic [PW-1:0] pq;
	assign pq = PW'(prio_q - 3'd1);
	logic [PW-1:0] wq;
	assign wq = PW'(level_q - 3'd1);
	logic [63:0] rd_end;
	assign rd_end = rd_q[63:0];

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.accepted = acc_q;
	assign rsp.active = (level_q != '0);
	assign rsp.playing_priority = level_q;
	assign rsp.pwm_wrap = wwrap_q;
	assign rsp.pwm_level = (level_q != '0) ? whigh_q : 16'd0;
	assign rsp.job_finished = fin_q;
	assign rsp.finished_priority = finp_q;

	// Memory address selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot(pq, head_q[pq], '0);
		mem_wd = {nwrap_q, nhigh_q, nend_q};
		mem_ra = slot(qi_q, head_q[qi_q], '0);
		if (state_q == ST_PUSH_RD || state_q == ST_PUSH_CHK) mem_ra = slot(pq, head_q[pq], '0);
		if (state_q == ST_PUSH_CHK && 32'(count_q[pq]) < QUEUE_DEPTH) begin
			mem_we = 1'b1;
			mem_wa = slot(pq, head_q[pq], count_q[pq]);
		end
		if (state_q == ST_DEC && op_q == OP_SUBMIT && prio_q != '0 && (fev_q || dur_q != 0)
			&& level_q != '0 && level_q > prio_q) begin
			mem_we = 1'b1;
			mem_wa = slot(wq, (head_q[wq] == '0) ? QW'(QUEUE_DEPTH - 1) : QW'(head_q[wq] - 1'b1),
				'0);
			mem_wd = {wwrap_q, whigh_q, wend_q};
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dflt_q <= DEFAULT_PRIO_RESET;
			time_q <= '0;
			level_q <= '0;
			wwrap_q <= '0;
			whigh_q <= '0;
			wend_q <= '0;
			op_q <= OP_SUBMIT;
			prio_q <= '0;
			nwrap_q <= '0;
			nhigh_q <= '0;
			dur_q <= '0;
			fev_q <= 1'b0;
			nend_q <= '0;
			now_q <= '0;
			acc_q <= 1'b0;
			fin_q <= 1'b0;
			finp_q <= '0;
			qi_q <= '0;
			for (int i = 0; i < NUM_PRIORITIES; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (cfg.valid) dflt_q <= cfg.data;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q <= req.opcode;
						prio_q <= eprio;
						nwrap_q <= req.wrap_count;
						nhigh_q <= req.high_count;
						dur_q <= req.duration_us;
						fev_q <= req.forever_req;
						nend_q <= req.forever_req ? FOREVER_END :
							(sum_end >= {1'b0, FOREVER_END}) ? FOREVER_END - 64'd1 :
							sum_end[63:0];
						acc_q <= 1'b0;
						fin_q <= 1'b0;
						finp_q <= '0;
						state_q <= (req.opcode == OP_TICK) ? ST_TICK : ST_DEC;
						if (req.opcode == OP_TICK) time_q <= time_q + 64'd1;
					end
				end
				ST_TICK: begin
					state_q <= ST_OUT;
					if (level_q != '0 && wend_q != FOREVER_END && wend_q <= time_q) begin
						fin_q <= 1'b1;
						finp_q <= level_q;
						now_q <= wend_q;
						qi_q <= '0;
						state_q <= ST_PICK_RD;
					end
				end
				ST_DEC: begin
					state_q <= ST_OUT;
					case (op_q)
						OP_SUBMIT: begin
							if (prio_q != '0) begin
								if (!fev_q && dur_q == 0) begin
									acc_q <= 1'b1;
								end else if (level_q != '0 && level_q <= prio_q) begin
									state_q <= ST_PUSH_RD;
								end else begin
									if (level_q != '0) begin
										head_q[wq] <= (head_q[wq] == '0) ?
											QW'(QUEUE_DEPTH - 1) : QW'(head_q[wq] - 1'b1);
										if (32'(count_q[wq]) < QUEUE_DEPTH)
											count_q[wq] <= count_q[wq] + 1'b1;
									end
									level_q <= prio_q;
									wwrap_q <= nwrap_q;
									whigh_q <= nhigh_q;
									wend_q <= nend_q;
									acc_q <= 1'b1;
								end
							end
						end
						OP_STOP: begin
							if (prio_q != '0) begin
								count_q[pq] <= '0;
								if (level_q == prio_q) begin
									now_q <= time_q;
									qi_q <= '0;
									state_q <= ST_PICK_RD;
								end
							end
						end
						default: begin
							level_q <= '0;
							for (int i = 0; i < NUM_PRIORITIES; i++) count_q[i] <= '0;
						end
					endcase
				end
				ST_PUSH_RD: state_q <= ST_PUSH_CHK;
				ST_PUSH_CHK: begin
					// Full queue: drop a stale front and look again, else reject the request.
					if (32'(count_q[pq]) >= QUEUE_DEPTH) begin
						if (rd_end <= time_q) begin
							head_q[pq] <= inc_h(head_q[pq]);
							count_q[pq] <= count_q[pq] - 1'b1;
							state_q <= ST_PUSH_RD;
						end else begin
							acc_q <= 1'b0;
							state_q <= ST_OUT;
						end
					end else begin
						count_q[pq] <= count_q[pq] + 1'b1;
						acc_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_PICK_RD: begin
					if (count_q[qi_q] != '0) begin
						state_q <= ST_PICK_CHK;
					end else if (32'(qi_q) == NUM_PRIORITIES - 1) begin
						level_q <= '0;
						state_q <= ST_OUT;
					end else begin
						qi_q <= qi_q + 1'b1;
					end
				end
				ST_PICK_CHK: begin
					head_q[qi_q] <= inc_h(head_q[qi_q]);
					count_q[qi_q] <= count_q[qi_q] - 1'b1;
					if (now_q < rd_end) begin
						level_q <= PRIO_W'(32'(qi_q) + 1);
						wwrap_q <= rd_q[95:80];
						whigh_q <= rd_q[79:64];
						wend_q <= rd_end;
						state_q <= ST_OUT;
					end else if (32'(qi_q) == NUM_PRIORITIES - 1) begin
						level_q <= '0;
						state_q <= ST_OUT;
					end else begin
						qi_q <= qi_q + 1'b1;
						state_q <= ST_PICK_RD;
					end
				end
				ST_OUT: if (rsp.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
